// ===== rtl/ssp_pkg.sv =====
// Shared constants, codes and types of the shortest path unit.
`timescale 1ns / 1ps

package ssp_pkg;

  localparam int MAX_VERTICES_DEF = 256;
  localparam int MAX_EDGES_DEF    = 4096;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int VERT_W  = 8;
  localparam int COUNT_W = 9;
  localparam int DIST_W  = 20;
  localparam int OP_W    = 2;

  localparam logic [DIST_W-1:0] UNREACHABLE = 20'd1000000;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_EDGE = 2'd0,
    OP_RUN      = 2'd1,
    OP_QUERY    = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RS_IDLE,
    RS_INIT,
    RS_SOURCE,
    RS_SCAN,
    RS_MARK,
    RS_EDGE_RD,
    RS_EDGE_CHK,
    RS_RELAX
  } run_state_t;

  typedef struct packed {
    logic              start;
    logic [VERT_W-1:0] source;
  } run_cmd_t;

endpackage

// ===== rtl/ssp_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module ssp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ssp_alu.sv =====
// Shared saturating add and less-than compare used by scan and relax steps.
`timescale 1ns / 1ps

module ssp_alu #(
  parameter int WEIGHT_BITS = ssp_pkg::WEIGHT_BITS_DEF
) (
  input  logic [ssp_pkg::DIST_W-1:0] base,
  input  logic [WEIGHT_BITS-1:0]     addend,
  input  logic [ssp_pkg::DIST_W-1:0] limit,
  output logic [ssp_pkg::DIST_W-1:0] sum,
  output logic                       less
);

  localparam int SUM_W = ssp_pkg::DIST_W + 1;

  logic [SUM_W-1:0] raw;

  always_comb begin
    raw  = SUM_W'(base) + SUM_W'(addend);
    sum  = (raw >= SUM_W'(ssp_pkg::UNREACHABLE)) ? ssp_pkg::UNREACHABLE
                                                  : raw[ssp_pkg::DIST_W-1:0];
    less = sum < limit;
  end

endmodule

// ===== rtl/ssp_ctrl.sv =====
// Run sequencer: distance sweep, minimum scan, marking and edge relaxation.
`timescale 1ns / 1ps

module ssp_ctrl #(
  parameter int MAX_VERTICES = ssp_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = ssp_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS  = ssp_pkg::WEIGHT_BITS_DEF,
  localparam int VA_W = $clog2(MAX_VERTICES),
  localparam int ET_W = $clog2(MAX_EDGES + 1),
  localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int EW   = 2 * ssp_pkg::VERT_W + WEIGHT_BITS,
  localparam int DW   = ssp_pkg::DIST_W + 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ssp_pkg::run_cmd_t           cmd,
  input  logic [ssp_pkg::COUNT_W-1:0] vertex_count,
  input  logic [ET_W-1:0]             edge_total,
  output logic [EA_W-1:0]             edge_raddr,
  input  logic [EW-1:0]               edge_rdata,
  output logic                        dist_we,
  output logic [VA_W-1:0]             dist_waddr,
  output logic [DW-1:0]               dist_wdata,
  output logic [VA_W-1:0]             dist_raddr,
  input  logic [DW-1:0]               dist_rdata,
  output logic                        busy
);

  localparam int DIST_W  = ssp_pkg::DIST_W;
  localparam int VERT_W  = ssp_pkg::VERT_W;
  localparam int COUNT_W = ssp_pkg::COUNT_W;

  ssp_pkg::run_state_t state, state_next;

  logic [VA_W-1:0]        sweep;
  logic [VERT_W-1:0]      source;
  logic [COUNT_W-1:0]     scan_i;
  logic                   scan_v;
  logic [VA_W-1:0]        scan_idx;
  logic [DIST_W-1:0]      best;
  logic [DIST_W-1:0]      du;
  logic [VA_W-1:0]        u_vtx;
  logic                   found;
  logic [ET_W-1:0]        e;
  logic [VA_W-1:0]        tgt;
  logic [WEIGHT_BITS-1:0] wgt;

  logic [VERT_W-1:0]      ea, eb;
  logic [WEIGHT_BITS-1:0] ew;
  logic                   a_in, b_in, a_hit, b_hit, relevant;
  logic [VA_W-1:0]        cand;
  logic                   src_ok, scan_more, sweep_last, edges_done;
  logic [DIST_W-1:0]      alu_base, alu_limit, alu_sum;
  logic [WEIGHT_BITS-1:0] alu_addend;
  logic                   alu_less;

  always_comb begin
    ea         = edge_rdata[EW-1 -: VERT_W];
    eb         = edge_rdata[EW-VERT_W-1 -: VERT_W];
    ew         = edge_rdata[WEIGHT_BITS-1:0];
    a_in       = COUNT_W'(ea) < vertex_count;
    b_in       = COUNT_W'(eb) < vertex_count;
    a_hit      = a_in && b_in && (VA_W'(ea) == u_vtx);
    b_hit      = a_in && b_in && (VA_W'(eb) == u_vtx);
    relevant   = a_hit ^ b_hit;
    cand       = a_hit ? VA_W'(eb) : VA_W'(ea);
    src_ok     = COUNT_W'(source) < vertex_count;
    scan_more  = scan_i < vertex_count;
    sweep_last = sweep == VA_W'(MAX_VERTICES - 1);
    edges_done = e == edge_total;
  end

  always_comb begin
    if (state == ssp_pkg::RS_SCAN) begin
      alu_base   = dist_rdata[DIST_W-1:0];
      alu_addend = '0;
      alu_limit  = best;
    end else begin
      alu_base   = du;
      alu_addend = wgt;
      alu_limit  = dist_rdata[DIST_W-1:0];
    end
  end

  ssp_alu #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_alu (
    .base  (alu_base),
    .addend(alu_addend),
    .limit (alu_limit),
    .sum   (alu_sum),
    .less  (alu_less)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ssp_pkg::RS_IDLE: begin
        if (cmd.start) begin
          state_next = ssp_pkg::RS_INIT;
        end
      end
      ssp_pkg::RS_INIT: begin
        if (sweep_last) begin
          state_next = ssp_pkg::RS_SOURCE;
        end
      end
      ssp_pkg::RS_SOURCE: begin
        state_next = src_ok ? ssp_pkg::RS_SCAN : ssp_pkg::RS_IDLE;
      end
      ssp_pkg::RS_SCAN: begin
        if (!scan_more && !scan_v) begin
          state_next = ssp_pkg::RS_MARK;
        end
      end
      ssp_pkg::RS_MARK: begin
        state_next = found ? ssp_pkg::RS_EDGE_RD : ssp_pkg::RS_IDLE;
      end
      ssp_pkg::RS_EDGE_RD: begin
        state_next = edges_done ? ssp_pkg::RS_SCAN : ssp_pkg::RS_EDGE_CHK;
      end
      ssp_pkg::RS_EDGE_CHK: begin
        state_next = relevant ? ssp_pkg::RS_RELAX : ssp_pkg::RS_EDGE_RD;
      end
      ssp_pkg::RS_RELAX: begin
        state_next = ssp_pkg::RS_EDGE_RD;
      end
      default: begin
        state_next = ssp_pkg::RS_IDLE;
      end
    endcase
  end

  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = '0;
    dist_wdata = '0;
    dist_raddr = '0;
    edge_raddr = EA_W'(e);
    busy       = state != ssp_pkg::RS_IDLE;
    unique case (state)
      ssp_pkg::RS_INIT: begin
        dist_we    = 1'b1;
        dist_waddr = sweep;
        dist_wdata = {1'b0, ssp_pkg::UNREACHABLE};
      end
      ssp_pkg::RS_SOURCE: begin
        dist_we    = src_ok;
        dist_waddr = VA_W'(source);
        dist_wdata = '0;
      end
      ssp_pkg::RS_SCAN: begin
        dist_raddr = VA_W'(scan_i);
      end
      ssp_pkg::RS_MARK: begin
        dist_we    = found;
        dist_waddr = u_vtx;
        dist_wdata = {1'b1, best};
      end
      ssp_pkg::RS_EDGE_CHK: begin
        dist_raddr = cand;
      end
      ssp_pkg::RS_RELAX: begin
        dist_we    = alu_less;
        dist_waddr = tgt;
        dist_wdata = {dist_rdata[DIST_W], alu_sum};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ssp_pkg::RS_IDLE;
      scan_v <= 1'b0;
      found  <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ssp_pkg::RS_IDLE: begin
          if (cmd.start) begin
            sweep  <= '0;
            source <= cmd.source;
          end
        end
        ssp_pkg::RS_INIT: begin
          sweep <= sweep + 1'b1;
        end
        ssp_pkg::RS_SOURCE: begin
          scan_i <= '0;
          scan_v <= 1'b0;
          best   <= ssp_pkg::UNREACHABLE;
          found  <= 1'b0;
        end
        ssp_pkg::RS_SCAN: begin
          if (scan_more) begin
            scan_i   <= scan_i + 1'b1;
            scan_v   <= 1'b1;
            scan_idx <= VA_W'(scan_i);
          end else begin
            scan_v <= 1'b0;
          end
          if (scan_v && !dist_rdata[DIST_W] && alu_less) begin
            best  <= dist_rdata[DIST_W-1:0];
            u_vtx <= scan_idx;
            found <= 1'b1;
          end
        end
        ssp_pkg::RS_MARK: begin
          du <= best;
          e  <= '0;
        end
        ssp_pkg::RS_EDGE_RD: begin
          if (edges_done) begin
            scan_i <= '0;
            scan_v <= 1'b0;
            best   <= ssp_pkg::UNREACHABLE;
            found  <= 1'b0;
          end
        end
        ssp_pkg::RS_EDGE_CHK: begin
          tgt <= cand;
          wgt <= ew;
          if (!relevant) begin
            e <= e + 1'b1;
          end
        end
        ssp_pkg::RS_RELAX: begin
          e <= e + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_mark_reachable: assert property (@(posedge clk) disable iff (rst)
    (state == ssp_pkg::RS_MARK && found) |-> best < ssp_pkg::UNREACHABLE)
    else $error("finished vertex marked with unreachable distance");

  a_start_from_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(cmd.start))
    else $error("run sequencer left idle without a start");
`endif

endmodule

// ===== rtl/single_source_shortest_path_unit.sv =====
// Top level of the single source shortest path unit: item handshake, stores, query output.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_ready  op, vertex_a, vertex_b, weight
//   out      output     out_valid/out_ready vertex, distance, reachable, edges_dropped
//   cfg      input      cfg_wen            cfg_wdata (vertex count)
//
// Add edge and clear words complete when accepted; a query word's result is read from the
// distance store on acceptance and loaded into the output register once that is free.
// A run holds in_ready low through the distance sweep and the source write, then per
// finished vertex a scan, a mark, a read and check of each stored edge with a relax where
// it improves, and an end-of-edges step, plus a last scan and mark that find no vertex.
// Reset clears control state only; a stalled output holds in_ready low only while a query
// result waits to load.
`timescale 1ns / 1ps

module single_source_shortest_path_unit #(
  parameter int MAX_VERTICES = ssp_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = ssp_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS  = ssp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic [ssp_pkg::COUNT_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ssp_pkg::OP_W-1:0]    op,
  input  logic [ssp_pkg::VERT_W-1:0]  vertex_a,
  input  logic [ssp_pkg::VERT_W-1:0]  vertex_b,
  input  logic [15:0]                 weight,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ssp_pkg::VERT_W-1:0]  vertex,
  output logic [ssp_pkg::DIST_W-1:0]  distance,
  output logic                        reachable,
  output logic                        edges_dropped
);

  localparam int VA_W    = $clog2(MAX_VERTICES);
  localparam int ET_W    = $clog2(MAX_EDGES + 1);
  localparam int EA_W    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW      = 2 * ssp_pkg::VERT_W + WEIGHT_BITS;
  localparam int DW      = ssp_pkg::DIST_W + 1;
  localparam int COUNT_W = ssp_pkg::COUNT_W;
  localparam int DIST_W  = ssp_pkg::DIST_W;
  localparam int VC_MAX_I = (MAX_VERTICES < 511) ? MAX_VERTICES : 511;
  localparam int VC_RST_I = (MAX_VERTICES < 256) ? MAX_VERTICES : 256;
  localparam logic [COUNT_W-1:0] VC_MAX = COUNT_W'(VC_MAX_I);
  localparam logic [COUNT_W-1:0] VC_RST = COUNT_W'(VC_RST_I);

  logic [COUNT_W-1:0]         vertex_count;
  logic [ET_W-1:0]            edge_total;
  logic                       overflow;
  logic                       results_ready;
  logic                       q_pend;
  logic                       q_ok;
  logic                       q_drop;
  logic [ssp_pkg::VERT_W-1:0] q_vertex;
  logic [VA_W-1:0]            q_addr;

  logic                       accept, acc_add, acc_run, acc_query, acc_clear;
  logic                       full, out_load, edge_we, run_busy;
  logic [COUNT_W-1:0]         cfg_value;
  logic [DIST_W-1:0]          q_dist;
  ssp_pkg::run_cmd_t          cmd;

  logic [EA_W-1:0]            edge_raddr;
  logic [EW-1:0]              edge_rdata;
  logic                       dist_we;
  logic [VA_W-1:0]            dist_waddr, ctrl_raddr, dist_raddr;
  logic [DW-1:0]              dist_wdata, dist_rdata;

  always_comb begin
    full       = edge_total == ET_W'(MAX_EDGES);
    out_load   = q_pend && (!out_valid || out_ready);
    in_ready   = !run_busy && !(q_pend && !out_load);
    accept     = in_valid && in_ready;
    acc_add    = accept && (op == ssp_pkg::OP_ADD_EDGE);
    acc_run    = accept && (op == ssp_pkg::OP_RUN);
    acc_query  = accept && (op == ssp_pkg::OP_QUERY);
    acc_clear  = accept && (op == ssp_pkg::OP_CLEAR);
    edge_we    = acc_add && !full;
    cmd.start  = acc_run;
    cmd.source = vertex_a;
    q_dist     = q_ok ? dist_rdata[DIST_W-1:0] : ssp_pkg::UNREACHABLE;
    if (run_busy) begin
      dist_raddr = ctrl_raddr;
    end else if (acc_query) begin
      dist_raddr = VA_W'(vertex_a);
    end else begin
      dist_raddr = q_addr;
    end
    if (cfg_wdata == '0) begin
      cfg_value = COUNT_W'(1);
    end else if (cfg_wdata > VC_MAX) begin
      cfg_value = VC_MAX;
    end else begin
      cfg_value = cfg_wdata;
    end
  end

  ssp_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_EDGES)
  ) u_edge_ram (
    .clk  (clk),
    .we   (edge_we),
    .waddr(EA_W'(edge_total)),
    .wdata({vertex_a, vertex_b, WEIGHT_BITS'(weight)}),
    .raddr(edge_raddr),
    .rdata(edge_rdata)
  );

  ssp_ram #(
    .WIDTH(DW),
    .DEPTH(MAX_VERTICES)
  ) u_dist_ram (
    .clk  (clk),
    .we   (dist_we),
    .waddr(dist_waddr),
    .wdata(dist_wdata),
    .raddr(dist_raddr),
    .rdata(dist_rdata)
  );

  ssp_ctrl #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_EDGES   (MAX_EDGES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .vertex_count(vertex_count),
    .edge_total  (edge_total),
    .edge_raddr  (edge_raddr),
    .edge_rdata  (edge_rdata),
    .dist_we     (dist_we),
    .dist_waddr  (dist_waddr),
    .dist_wdata  (dist_wdata),
    .dist_raddr  (ctrl_raddr),
    .dist_rdata  (dist_rdata),
    .busy        (run_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= VC_RST;
      edge_total    <= '0;
      overflow      <= 1'b0;
      results_ready <= 1'b0;
      q_pend        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wen) begin
        vertex_count <= cfg_value;
      end
      if (acc_add) begin
        if (full) begin
          overflow <= 1'b1;
        end else begin
          edge_total <= edge_total + 1'b1;
        end
      end
      if (acc_run) begin
        results_ready <= 1'b1;
      end
      if (acc_clear) begin
        edge_total    <= '0;
        overflow      <= 1'b0;
        results_ready <= 1'b0;
      end
      if (acc_query) begin
        q_pend <= 1'b1;
      end else if (out_load) begin
        q_pend <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_query) begin
      q_ok     <= results_ready && (COUNT_W'(vertex_a) < vertex_count);
      q_drop   <= overflow;
      q_vertex <= vertex_a;
      q_addr   <= VA_W'(vertex_a);
    end
    if (out_load) begin
      vertex        <= q_vertex;
      distance      <= q_dist;
      reachable     <= q_dist < ssp_pkg::UNREACHABLE;
      edges_dropped <= q_drop;
    end
  end

`ifndef NO_ASSERTIONS
  a_edge_total_bound: assert property (@(posedge clk) disable iff (rst)
    edge_total <= ET_W'(MAX_EDGES))
    else $error("edge count beyond store capacity");

  a_out_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(q_pend))
    else $error("result word without a pending query");

  a_query_not_in_run: assert property (@(posedge clk) disable iff (rst)
    !(q_pend && run_busy))
    else $error("query read pending while a run owns the distance store");
`endif

endmodule

// ===== dv/single_source_shortest_path_unit_tb.sv =====
// Testbench for the shortest path unit: graph and run stimulus with a distance predictor.
`timescale 1ns / 1ps

module single_source_shortest_path_unit_tb;
  import ssp_pkg::*;

  typedef struct packed {
    logic [VERT_W-1:0] vtx;
    logic [DIST_W-1:0] dist_val;
    logic              reach;
    logic              dropped;
  } query_result_t;

  class path_scoreboard;
    int unsigned   vcount;
    int unsigned   edge_a [MAX_EDGES_DEF];
    int unsigned   edge_b [MAX_EDGES_DEF];
    int unsigned   edge_w [MAX_EDGES_DEF];
    int unsigned   edge_total;
    int unsigned   dist_tab [MAX_VERTICES_DEF];
    bit            done_mark [MAX_VERTICES_DEF];
    bit            dist_valid;
    bit            dropped;
    query_result_t expected_q[$];
    int            errors;

    function new();
      vcount = (MAX_VERTICES_DEF < 256) ? MAX_VERTICES_DEF : 256;
      edge_total = 0;
      dist_valid = 1'b0;
      dropped = 1'b0;
      errors = 0;
      foreach (dist_tab[i]) dist_tab[i] = 0;
    endfunction

    function void set_vertex_count(int unsigned value);
      int unsigned v;
      v = value & 'h1FF;
      if (v < 1) v = 1;
      if (v > MAX_VERTICES_DEF) v = MAX_VERTICES_DEF;
      vcount = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void relax(int unsigned from, int unsigned to, int unsigned w);
      int unsigned sum;
      sum = dist_tab[from] + w;
      if (sum >= UNREACHABLE) sum = UNREACHABLE;
      if (dist_tab[to] > sum) dist_tab[to] = sum;
    endfunction

    function void note_input(op_t code, logic [VERT_W-1:0] va, logic [VERT_W-1:0] vb,
                             logic [15:0] wt);
      int unsigned   w, best, u, i, e, a, b, d;
      bit            found;
      query_result_t r;
      w = wt & ((1 << WEIGHT_BITS_DEF) - 1);
      case (code)
        OP_ADD_EDGE: begin
          if (edge_total >= MAX_EDGES_DEF) begin
            dropped = 1'b1;
          end else begin
            edge_a[edge_total] = va;
            edge_b[edge_total] = vb;
            edge_w[edge_total] = w;
            edge_total++;
          end
        end
        OP_RUN: begin
          for (i = 0; i < MAX_VERTICES_DEF; i++) begin
            dist_tab[i] = UNREACHABLE;
            done_mark[i] = 1'b0;
          end
          dist_valid = 1'b1;
          if (va < vcount) begin
            dist_tab[va] = 0;
            found = 1'b1;
            while (found) begin
              best = UNREACHABLE;
              u = 0;
              found = 1'b0;
              for (i = 0; i < vcount; i++) begin
                if (!done_mark[i] && dist_tab[i] < best) begin
                  best = dist_tab[i];
                  u = i;
                  found = 1'b1;
                end
              end
              if (found) begin
                done_mark[u] = 1'b1;
                for (e = 0; e < edge_total; e++) begin
                  a = edge_a[e];
                  b = edge_b[e];
                  if (a < vcount && b < vcount) begin
                    if (a == u) relax(u, b, edge_w[e]);
                    if (b == u) relax(u, a, edge_w[e]);
                  end
                end
              end
            end
          end
        end
        OP_QUERY: begin
          d = UNREACHABLE;
          if (dist_valid && va < vcount) d = dist_tab[va];
          r.vtx = va;
          r.dist_val = d[DIST_W-1:0];
          r.reach = (d < UNREACHABLE);
          r.dropped = dropped;
          expected_q = {expected_q, r};
        end
        default: begin
          edge_total = 0;
          dropped = 1'b0;
          dist_valid = 1'b0;
        end
      endcase
    endfunction

    function void check_result(logic [VERT_W-1:0] vtx, logic [DIST_W-1:0] dist_out,
                               logic reach, logic drop);
      query_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: vertex %0d distance %0d reachable %0b dropped %0b",
                   vtx, dist_out, reach, drop);
        return;
      end
      want = expected_q.pop_front();
      if (want.vtx !== vtx || want.dist_val !== dist_out || want.reach !== reach ||
          want.dropped !== drop) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected vertex %0d distance %0d reachable %0b dropped %0b, %s",
                   want.vtx, want.dist_val, want.reach, want.dropped, "got below");
        if (errors <= 10)
          $display("          actual   vertex %0d distance %0d reachable %0b dropped %0b",
                   vtx, dist_out, reach, drop);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_wen;
  logic [COUNT_W-1:0]  cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [OP_W-1:0]     op;
  logic [VERT_W-1:0]   vertex_a;
  logic [VERT_W-1:0]   vertex_b;
  logic [15:0]         weight;
  logic                out_valid;
  logic                out_ready;
  logic [VERT_W-1:0]   vertex;
  logic [DIST_W-1:0]   distance;
  logic                reachable;
  logic                edges_dropped;

  path_scoreboard sb;
  int             tx_idle_pct;
  int             rx_stall_pct;
  logic           rx_hold;
  event           hold_go;
  int unsigned    words_sent;
  int unsigned    vc_list [8] = '{16, 256, 2, 37, 0, 511, 9, 300};

  single_source_shortest_path_unit #(
    .MAX_VERTICES(MAX_VERTICES_DEF),
    .MAX_EDGES(MAX_EDGES_DEF),
    .WEIGHT_BITS(WEIGHT_BITS_DEF)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .vertex_a(vertex_a),
    .vertex_b(vertex_b),
    .weight(weight),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .vertex(vertex),
    .distance(distance),
    .reachable(reachable),
    .edges_dropped(edges_dropped)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #200_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rx_hold = 1'b0;
    @(hold_go);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(vertex, distance, reachable, edges_dropped);
      out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  task automatic set_mode(int unsigned mode);
    case (mode)
      0: begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end
      1: begin
        tx_idle_pct = 49;
        rx_stall_pct = 0;
      end
      2: begin
        tx_idle_pct = 0;
        rx_stall_pct = 49;
      end
      default: begin
        tx_idle_pct = 11;
        rx_stall_pct = 11;
      end
    endcase
  endtask

  task automatic send_word(op_t code, int unsigned a, int unsigned b, int unsigned wt);
    logic [VERT_W-1:0] a_bits;
    logic [VERT_W-1:0] b_bits;
    logic [15:0]       w_bits;
    a_bits = VERT_W'(a);
    b_bits = VERT_W'(b);
    w_bits = 16'(wt);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    vertex_a <= a_bits;
    vertex_b <= b_bits;
    weight <= w_bits;
    do @(posedge clk); while (!in_ready);
    sb.note_input(code, a_bits, b_bits, w_bits);
    words_sent++;
  endtask

  // Hold the sender until every query result is back and the block is idle.
  task automatic drain();
    send_word(OP_QUERY, $urandom, $urandom, $urandom);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_vertex_count(int unsigned value);
    cfg_wdata <= COUNT_W'(value);
    cfg_wen <= 1'b1;
    @(posedge clk);
    sb.set_vertex_count(value);
    cfg_wen <= 1'b0;
  endtask

  function automatic int unsigned pick_vertex(int unsigned span);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, span - 1);
  endfunction

  task automatic random_sequence();
    int unsigned vc, span, pick, len, i;
    int unsigned wt;
    vc = sb.vcount;
    span = (vc < 12) ? vc : 12;
    pick = $urandom_range(0, 9);
    if (sb.edge_total > 24) send_word(OP_CLEAR, $urandom, $urandom, $urandom);
    if (pick <= 5) begin
      if ($urandom_range(0, 1)) send_word(OP_CLEAR, $urandom, $urandom, $urandom);
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 3))
          0: wt = $urandom_range(0, 15);
          1: wt = $urandom;
          2: wt = 16'hFFFF;
          default: wt = $urandom_range(0, 300);
        endcase
        send_word(OP_ADD_EDGE, pick_vertex(span), pick_vertex(span), wt);
      end
      if ($urandom_range(0, 3) == 0) send_word(OP_QUERY, pick_vertex(span), $urandom, $urandom);
      send_word(OP_RUN, pick_vertex(span), $urandom, $urandom);
      repeat ($urandom_range(1, 6))
        send_word(OP_QUERY, pick_vertex(span), $urandom, $urandom);
    end else if (pick <= 7 && vc >= 20) begin
      send_word(OP_CLEAR, $urandom, $urandom, $urandom);
      len = $urandom_range(14, 18);
      for (i = 0; i < len; i++)
        send_word(OP_ADD_EDGE, i, i + 1, $urandom_range(60000, 65535));
      send_word(OP_RUN, 0, $urandom, $urandom);
      for (i = len - 3; i <= len; i++)
        send_word(OP_QUERY, i, $urandom, $urandom);
    end else begin
      repeat ($urandom_range(1, 6))
        send_word(op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    int unsigned i, p, start_count;
    sb = new();
    words_sent = 0;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    op = OP_ADD_EDGE;
    vertex_a = '0;
    vertex_b = '0;
    weight = '0;
    set_mode(0);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(OP_QUERY, 0, 0, 0);
    send_word(OP_ADD_EDGE, 0, 255, 16'hFFFF);
    send_word(OP_ADD_EDGE, 255, 1, 0);
    send_word(OP_ADD_EDGE, 1, 1, 7);
    send_word(OP_ADD_EDGE, 1, 2, 0);
    send_word(OP_ADD_EDGE, 2, 200, 12345);
    send_word(OP_ADD_EDGE, 3, 4, 1);
    send_word(OP_RUN, 0, 8'hFF, 16'hFFFF);
    send_word(OP_QUERY, 0, 0, 0);
    send_word(OP_QUERY, 255, 0, 0);
    send_word(OP_QUERY, 1, 0, 0);
    send_word(OP_QUERY, 2, 0, 0);
    send_word(OP_QUERY, 200, 0, 0);
    send_word(OP_QUERY, 3, 0, 0);
    send_word(OP_CLEAR, 0, 0, 0);
    send_word(OP_QUERY, 1, 0, 0);
    drain();
    write_vertex_count(3);
    send_word(OP_ADD_EDGE, 0, 5, 1);
    send_word(OP_ADD_EDGE, 0, 2, 9);
    send_word(OP_RUN, 7, 0, 0);
    send_word(OP_QUERY, 0, 0, 0);
    send_word(OP_RUN, 0, 0, 0);
    send_word(OP_QUERY, 2, 0, 0);
    send_word(OP_QUERY, 5, 0, 0);
    drain();
    write_vertex_count(1);
    send_word(OP_QUERY, 2, 0, 0);
    drain();

    set_mode(3);
    write_vertex_count(4);
    send_word(OP_CLEAR, 0, 0, 0);
    for (i = 0; i < 40; i++)
      send_word(OP_ADD_EDGE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
    for (i = 0; i < 4; i++) send_word(OP_QUERY, i, 0, 0);
    send_word(OP_RUN, 0, 0, 0);
    for (i = 0; i < 5; i++) send_word(OP_QUERY, i, 0, 0);
    send_word(OP_CLEAR, 0, 0, 0);
    send_word(OP_QUERY, 0, 0, 0);
    drain();

    for (p = 0; p < 8; p++) begin
      set_mode(p % 4);
      write_vertex_count(vc_list[p]);
      start_count = words_sent;
      while (words_sent - start_count < 80) random_sequence();
      drain();
    end

    set_mode(0);
    write_vertex_count(16);
    -> hold_go;
    repeat (60) send_word(OP_QUERY, $urandom_range(0, 15), $urandom, $urandom);
    drain();

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
